### sv/tst_pkg.sv
// Shared types, constants and register codes for the telemetry source tracker.
`default_nettype none

package tst_pkg;

    localparam int SOURCE_SLOTS = 8;
    localparam int SLOT_IDX_W   = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int SLOT_CNT_W   = $clog2(SOURCE_SLOTS + 1);
    localparam int TARGET_SLOT_W = 3;
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;

    localparam logic [31:0] DEF_HB_INTERVAL = 32'd1000;
    localparam logic [15:0] DEF_TEL_TIMEOUT = 16'd3000;
    localparam logic [15:0] DEF_REQ_RETRY   = 16'd2000;
    localparam logic [15:0] DEF_HB_MAX_AGE  = 16'd5000;
    localparam logic [7:0]  PRIO_SYS_LOW    = 8'd1;
    localparam logic [7:0]  PRIO_SYS_HIGH   = 8'd100;

    typedef logic [SLOT_IDX_W-1:0]    slot_idx_t;
    typedef logic [SLOT_CNT_W-1:0]    slot_cnt_t;
    typedef logic [TARGET_SLOT_W-1:0] target_slot_t;

    typedef enum logic [2:0] {
        REG_HB_ENABLE   = 3'd0,
        REG_HB_INTERVAL = 3'd1,
        REG_TEL_TIMEOUT = 3'd2,
        REG_REQ_RETRY   = 3'd3,
        REG_HB_MAX_AGE  = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [63:0] now_ms;
        logic        heartbeat_seen;
        logic [7:0]  hb_system;
        logic [7:0]  hb_component;
        logic        telemetry_seen;
        logic [7:0]  telemetry_system;
        logic [7:0]  telemetry_component;
        logic [47:0] source_address;
    } event_t;

    typedef struct packed {
        logic                     target_valid;
        logic [TARGET_SLOT_W-1:0] target_slot;
        logic [7:0]               target_system;
        logic [7:0]               target_component;
        logic [47:0]              target_address;
        logic                     target_changed;
        logic                     send_heartbeat;
        logic                     send_stream_request;
    } result_t;

    typedef struct packed {
        logic        hb_enable;
        logic        hb_enable_wr;
        logic [31:0] hb_interval;
        logic [15:0] tel_timeout;
        logic [15:0] req_retry;
        logic [15:0] hb_max_age;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  system;
        logic [7:0]  component;
        logic [47:0] address;
        logic [63:0] hb_time;
        logic [63:0] tel_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### sv/telemetry_source_tracker.sv
// Top level of the telemetry source tracker: configuration registers and table sequencer.
`default_nettype none

// The source table lives in one RAM with a single read port, and every accepted event
// walks it twice, once to look up and allocate senders and once to pick the target,
// with the write-back states WRITE_HB and WRITE_TEL between the walks. A new event is
// accepted as soon as the previous result has been loaded into the output register,
// while that result may still wait for result_ready. The table needs no clearing
// pass after reset; slot occupancy is held in flip-flops.
module telemetry_source_tracker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tst_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tst_pkg::PDATA_W-1:0] pwdata,
    output logic      [tst_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        event_valid,
    output logic                             event_ready,
    input  wire tst_pkg::event_t             event_word,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output tst_pkg::result_t                 result_word
);

    tst_pkg::cfg_t cfg;

    tst_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tst_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .event_valid  (event_valid),
        .event_ready  (event_ready),
        .event_word   (event_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

endmodule

`default_nettype wire

### sv/tst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/tst_regs.sv
// APB-style configuration registers of the telemetry source tracker.
`default_nettype none

module tst_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tst_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tst_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tst_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output tst_pkg::cfg_t                      cfg
);

    logic        en_reg, en_next;
    logic [31:0] interval_reg, interval_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [15:0] retry_reg, retry_next;
    logic [15:0] max_age_reg, max_age_next;
    logic        wr;
    tst_pkg::reg_index_t idx;

    assign wr  = psel && penable && pwrite;
    assign idx = tst_pkg::reg_index_t'(paddr[tst_pkg::PADDR_W-1:2]);

    always_comb
    begin
        en_next       = en_reg;
        interval_next = interval_reg;
        timeout_next  = timeout_reg;
        retry_next    = retry_reg;
        max_age_next  = max_age_reg;
        if (wr)
        begin
            case (idx)
                tst_pkg::REG_HB_ENABLE:   en_next = pwdata[0];
                tst_pkg::REG_HB_INTERVAL:
                begin
                    interval_next = (pwdata == '0) ? tst_pkg::DEF_HB_INTERVAL : pwdata;
                end
                tst_pkg::REG_TEL_TIMEOUT: timeout_next = pwdata[15:0];
                tst_pkg::REG_REQ_RETRY:   retry_next = pwdata[15:0];
                tst_pkg::REG_HB_MAX_AGE:  max_age_next = pwdata[15:0];
                default:                  en_next = en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg       <= 1'b0;
            interval_reg <= tst_pkg::DEF_HB_INTERVAL;
            timeout_reg  <= tst_pkg::DEF_TEL_TIMEOUT;
            retry_reg    <= tst_pkg::DEF_REQ_RETRY;
            max_age_reg  <= tst_pkg::DEF_HB_MAX_AGE;
        end
        else
        begin
            en_reg       <= en_next;
            interval_reg <= interval_next;
            timeout_reg  <= timeout_next;
            retry_reg    <= retry_next;
            max_age_reg  <= max_age_next;
        end
    end

    always_comb
    begin
        case (idx)
            tst_pkg::REG_HB_ENABLE:   prdata = {31'b0, en_reg};
            tst_pkg::REG_HB_INTERVAL: prdata = interval_reg;
            tst_pkg::REG_TEL_TIMEOUT: prdata = {16'b0, timeout_reg};
            tst_pkg::REG_REQ_RETRY:   prdata = {16'b0, retry_reg};
            tst_pkg::REG_HB_MAX_AGE:  prdata = {16'b0, max_age_reg};
            default:                  prdata = '0;
        endcase
    end

    assign pready           = 1'b1;
    assign cfg.hb_enable    = en_reg;
    assign cfg.hb_enable_wr = wr && (idx == tst_pkg::REG_HB_ENABLE);
    assign cfg.hb_interval  = interval_reg;
    assign cfg.tel_timeout  = timeout_reg;
    assign cfg.req_retry    = retry_reg;
    assign cfg.hb_max_age   = max_age_reg;

endmodule

`default_nettype wire

### sv/tst_core.sv
// Source table sequencer: lookup/allocate scan, write-back, target scan, send decision.
`default_nettype none

module tst_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tst_pkg::cfg_t    cfg,
    input  wire logic             event_valid,
    output logic                  event_ready,
    input  wire tst_pkg::event_t  event_word,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output tst_pkg::result_t      result_word
);

    typedef enum logic [5:0] {
        IDLE        = 6'b000001,
        SCAN_FIND   = 6'b000010,
        WRITE_HB    = 6'b000100,
        WRITE_TEL   = 6'b001000,
        SCAN_TARGET = 6'b010000,
        FINISH      = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    tst_pkg::slot_cnt_t cnt_reg, cnt_next;
    logic [tst_pkg::SOURCE_SLOTS-1:0] used_reg, used_next;
    tst_pkg::event_t ev_reg, ev_next;

    logic hb_found_reg, hb_found_next;
    logic free_found_reg, free_found_next;
    logic tel_found_reg, tel_found_next;
    logic best_found_reg, best_found_next;
    tst_pkg::slot_idx_t hb_idx_reg, hb_idx_next;
    tst_pkg::slot_idx_t free_idx_reg, free_idx_next;
    tst_pkg::slot_idx_t old_idx_reg, old_idx_next;
    tst_pkg::slot_idx_t tel_idx_reg, tel_idx_next;
    tst_pkg::slot_idx_t best_idx_reg, best_idx_next;
    logic [63:0] hb_tel_reg, hb_tel_next;
    logic [63:0] old_time_reg, old_time_next;
    logic [63:0] tel_hb_reg, tel_hb_next;
    logic [16:0] best_key_reg, best_key_next;
    tst_pkg::entry_t best_reg, best_next;

    logic cur_valid_reg, cur_valid_next;
    tst_pkg::slot_idx_t cur_slot_reg, cur_slot_next;
    logic [63:0] lhb_reg, lhb_next;
    logic [63:0] lrq_reg, lrq_next;
    logic out_valid_reg, out_valid_next;
    tst_pkg::result_t out_word_reg, out_word_next;

    logic we;
    tst_pkg::slot_idx_t waddr, raddr, proc_idx, hb_slot;
    tst_pkg::slot_cnt_t cnt_m1;
    tst_pkg::entry_t wentry, rentry;
    logic [tst_pkg::ENTRY_W-1:0] rdata;
    logic proc, last, used_i, prio, active;
    logic [16:0] key;
    logic tel_merge, tel_clobbered, tel_sep;
    logic changed, send_hb, send_req, tel_fresh, req_recent;
    logic [63:0] lhb_eff, lrq_eff;

    tst_ram #(
        .WIDTH (tst_pkg::ENTRY_W),
        .DEPTH (tst_pkg::SOURCE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rentry   = tst_pkg::entry_t'(rdata);
    assign cnt_m1   = cnt_reg - 1'b1;
    assign proc_idx = cnt_m1[tst_pkg::SLOT_IDX_W-1:0];
    assign raddr    = cnt_reg[tst_pkg::SLOT_IDX_W-1:0];
    assign proc     = (cnt_reg != '0);
    assign last     = (cnt_reg == tst_pkg::slot_cnt_t'(tst_pkg::SOURCE_SLOTS));
    assign used_i   = used_reg[proc_idx];

    assign hb_slot = hb_found_reg ? hb_idx_reg : (free_found_reg ? free_idx_reg : old_idx_reg);
    assign tel_merge = ev_reg.heartbeat_seen && ev_reg.telemetry_seen
                    && (ev_reg.telemetry_system == ev_reg.hb_system)
                    && (ev_reg.telemetry_component == ev_reg.hb_component);
    assign tel_clobbered = ev_reg.heartbeat_seen && !hb_found_reg && (hb_slot == tel_idx_reg);
    assign tel_sep = ev_reg.telemetry_seen && !tel_merge && tel_found_reg && !tel_clobbered;

    always_comb
    begin
        prio   = rentry.system inside {[tst_pkg::PRIO_SYS_LOW:tst_pkg::PRIO_SYS_HIGH]};
        key    = {!prio, rentry.system, rentry.component};
        active = used_i && (rentry.hb_time != '0)
              && ((ev_reg.now_ms - rentry.hb_time) <= {48'b0, cfg.hb_max_age});
    end

    // table write port
    always_comb
    begin
        we     = 1'b0;
        waddr  = hb_slot;
        wentry = '0;
        case (state_reg)
            WRITE_HB:
            begin
                we               = ev_reg.heartbeat_seen;
                wentry.system    = ev_reg.hb_system;
                wentry.component = ev_reg.hb_component;
                wentry.address   = ev_reg.source_address;
                wentry.hb_time   = ev_reg.now_ms;
                wentry.tel_time  = tel_merge ? ev_reg.now_ms
                                 : (hb_found_reg ? hb_tel_reg : 64'd0);
            end
            WRITE_TEL:
            begin
                we               = tel_sep;
                waddr            = tel_idx_reg;
                wentry.system    = ev_reg.telemetry_system;
                wentry.component = ev_reg.telemetry_component;
                wentry.address   = ev_reg.source_address;
                wentry.hb_time   = tel_hb_reg;
                wentry.tel_time  = ev_reg.now_ms;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // send decision
    always_comb
    begin
        changed    = best_found_reg ? (!cur_valid_reg || (cur_slot_reg != best_idx_reg))
                                    : cur_valid_reg;
        lhb_eff    = changed ? 64'd0 : lhb_reg;
        lrq_eff    = changed ? 64'd0 : lrq_reg;
        send_hb    = best_found_reg && cfg.hb_enable
                  && ((lhb_eff == '0) || ((ev_reg.now_ms - lhb_eff) >= {32'b0, cfg.hb_interval}));
        tel_fresh  = (best_reg.tel_time != '0)
                  && ((ev_reg.now_ms - best_reg.tel_time) <= {48'b0, cfg.tel_timeout});
        req_recent = (lrq_eff != '0)
                  && ((ev_reg.now_ms - lrq_eff) <= {48'b0, cfg.req_retry});
        send_req   = best_found_reg && !tel_fresh && !req_recent;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        ev_next         = ev_reg;
        hb_found_next   = hb_found_reg;
        free_found_next = free_found_reg;
        tel_found_next  = tel_found_reg;
        best_found_next = best_found_reg;
        hb_idx_next     = hb_idx_reg;
        free_idx_next   = free_idx_reg;
        old_idx_next    = old_idx_reg;
        tel_idx_next    = tel_idx_reg;
        best_idx_next   = best_idx_reg;
        hb_tel_next     = hb_tel_reg;
        old_time_next   = old_time_reg;
        tel_hb_next     = tel_hb_reg;
        best_key_next   = best_key_reg;
        best_next       = best_reg;
        cur_valid_next  = cur_valid_reg;
        cur_slot_next   = cur_slot_reg;
        lhb_next        = cfg.hb_enable_wr ? 64'd0 : lhb_reg;
        lrq_next        = lrq_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_word_next   = out_word_reg;

        case (state_reg)
            IDLE:
            begin
                if (event_valid)
                begin
                    ev_next         = event_word;
                    cnt_next        = '0;
                    hb_found_next   = 1'b0;
                    free_found_next = 1'b0;
                    tel_found_next  = 1'b0;
                    state_next      = SCAN_FIND;
                end
            end
            SCAN_FIND:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (proc)
                begin
                    if (used_i && !hb_found_reg
                        && (rentry.system == ev_reg.hb_system)
                        && (rentry.component == ev_reg.hb_component))
                    begin
                        hb_found_next = 1'b1;
                        hb_idx_next   = proc_idx;
                        hb_tel_next   = rentry.tel_time;
                    end
                    if (used_i && !tel_found_reg
                        && (rentry.system == ev_reg.telemetry_system)
                        && (rentry.component == ev_reg.telemetry_component))
                    begin
                        tel_found_next = 1'b1;
                        tel_idx_next   = proc_idx;
                        tel_hb_next    = rentry.hb_time;
                    end
                    if (!used_i && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = proc_idx;
                    end
                    if (used_i && ((proc_idx == '0) || (rentry.hb_time < old_time_reg)))
                    begin
                        old_idx_next  = proc_idx;
                        old_time_next = rentry.hb_time;
                    end
                end
                if (last)
                begin
                    state_next = WRITE_HB;
                end
            end
            WRITE_HB:
            begin
                if (ev_reg.heartbeat_seen)
                begin
                    used_next[hb_slot] = 1'b1;
                end
                state_next = WRITE_TEL;
            end
            WRITE_TEL:
            begin
                cnt_next        = '0;
                best_found_next = 1'b0;
                state_next      = SCAN_TARGET;
            end
            SCAN_TARGET:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (proc && active && (!best_found_reg || (key < best_key_reg)))
                begin
                    best_found_next = 1'b1;
                    best_key_next   = key;
                    best_idx_next   = proc_idx;
                    best_next       = rentry;
                end
                if (last)
                begin
                    state_next = FINISH;
                end
            end
            FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next.target_valid     = best_found_reg;
                    out_word_next.target_slot      = best_found_reg
                        ? tst_pkg::target_slot_t'(best_idx_reg) : '0;
                    out_word_next.target_system    = best_found_reg ? best_reg.system : '0;
                    out_word_next.target_component = best_found_reg ? best_reg.component : '0;
                    out_word_next.target_address   = best_found_reg ? best_reg.address : '0;
                    out_word_next.target_changed   = changed;
                    out_word_next.send_heartbeat   = send_hb;
                    out_word_next.send_stream_request = send_req;
                    cur_valid_next = best_found_reg;
                    cur_slot_next  = best_found_reg ? best_idx_reg : '0;
                    lhb_next       = send_hb ? ev_reg.now_ms : lhb_eff;
                    lrq_next       = send_req ? ev_reg.now_ms : lrq_eff;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            cnt_reg        <= '0;
            used_reg       <= '0;
            hb_found_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            tel_found_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            cur_valid_reg  <= 1'b0;
            cur_slot_reg   <= '0;
            lhb_reg        <= '0;
            lrq_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            used_reg       <= used_next;
            hb_found_reg   <= hb_found_next;
            free_found_reg <= free_found_next;
            tel_found_reg  <= tel_found_next;
            best_found_reg <= best_found_next;
            cur_valid_reg  <= cur_valid_next;
            cur_slot_reg   <= cur_slot_next;
            lhb_reg        <= lhb_next;
            lrq_reg        <= lrq_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg       <= ev_next;
        hb_idx_reg   <= hb_idx_next;
        free_idx_reg <= free_idx_next;
        old_idx_reg  <= old_idx_next;
        tel_idx_reg  <= tel_idx_next;
        best_idx_reg <= best_idx_next;
        hb_tel_reg   <= hb_tel_next;
        old_time_reg <= old_time_next;
        tel_hb_reg   <= tel_hb_next;
        best_key_reg <= best_key_next;
        best_reg     <= best_next;
        out_word_reg <= out_word_next;
    end

    assign event_ready  = (state_reg == IDLE);
    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_no_target_no_send: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_word_reg.target_valid)
        |-> (!out_word_reg.send_heartbeat && !out_word_reg.send_stream_request))
        else $error("send flag raised without a target");

    a_cur_slot_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cur_valid_reg |-> (cur_slot_reg == '0))
        else $error("current slot set without a valid target");

    a_used_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (($past(used_reg) & ~used_reg) == '0))
        else $error("a used slot was released");

    a_hb_allocates: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WRITE_HB && ev_reg.heartbeat_seen) |=> used_reg[$past(hb_slot)])
        else $error("heartbeat slot not marked used");
`endif

endmodule

`default_nettype wire
